### rtl/core/ipv4lpm_pkg.sv
// ----------------------------------------------------------------------------
// ipv4lpm_pkg
// Shared types and codes for the IPv4 longest-prefix forwarding block.
// ----------------------------------------------------------------------------
package ipv4lpm_pkg;

    // Address and field widths fixed by the datagram format.
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 6;
    localparam int IFACE_W = 4;
    localparam int TTL_W   = 8;

    // Longest legal prefix length.
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    // Result codes carried on the status field.
    typedef enum logic [2:0] {
        ST_FORWARDED   = 3'd0,
        ST_NO_ROUTE    = 3'd1,
        ST_TTL_EXPIRED = 3'd2,
        ST_ADDED       = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    // Command codes on the command field.
    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_ROUTE = 1'b1
    } command_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_DRAIN,
        S_RESOLVE,
        S_DONE
    } state_t;

    // One stored route.
    typedef struct packed {
        logic [ADDR_W-1:0]  prefix;
        logic [LEN_W-1:0]   length;
        logic               hop_valid;
        logic [ADDR_W-1:0]  hop_addr;
        logic [IFACE_W-1:0] iface;
    } route_entry_t;

endpackage

### rtl/core/ipv4lpm_table.sv
// ----------------------------------------------------------------------------
// ipv4lpm_table
// Route table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ipv4lpm_table
    import ipv4lpm_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  route_entry_t     wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output route_entry_t     rdata
);

    route_entry_t mem [DEPTH];
    route_entry_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/ipv4lpm_match.sv
// ----------------------------------------------------------------------------
// ipv4lpm_match
// Shared compare unit: tests one route against the destination and decides
// whether it beats the best match found so far.
// ----------------------------------------------------------------------------
module ipv4lpm_match
    import ipv4lpm_pkg::*;
(
    input  logic [ADDR_W-1:0] dest,
    input  route_entry_t      entry,
    input  logic              best_found,
    input  logic [LEN_W-1:0]  best_len,
    output logic              take
);

    logic [ADDR_W-1:0] mask;
    logic              hit;

    // A length of zero gives an empty mask; a length of 32 covers every bit.
    assign mask = ~({ADDR_W{1'b1}} >> entry.length);
    assign hit  = ((dest ^ entry.prefix) & mask) == '0;

    // Strictly longer wins, so the earliest of equal lengths is kept.
    assign take = hit && (!best_found || (entry.length > best_len));

endmodule

### rtl/core/ipv4_longest_prefix_router.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router
// IPv4 forwarding with an appendable route table and longest-prefix lookup.
// ----------------------------------------------------------------------------
//   Channel   Signals                               Beat
//   in        in_valid / in_stall + 8 fields        one add or route command
//   out       out_valid / out_stall + 4 fields      one result per command
//
// An add runs S_ADD then S_DONE; a route runs S_SCAN, S_DRAIN, S_RESOLVE
// and S_DONE (S_RESOLVE and S_DONE alone with an empty table): the sequencer
// reads one table entry per cycle through the single memory read port into
// the shared compare unit. in_stall is high while a command is in work; a
// result held by out_stall does not block the next beat, which waits only
// when its own result is ready. Reset clears the control registers only.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router
    import ipv4lpm_pkg::*;
#(
    parameter int TABLE_DEPTH    = 64,
    parameter int NUM_INTERFACES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [ADDR_W-1:0]   route_prefix_in,
    input  logic [LEN_W-1:0]    route_length_in,
    input  logic                has_next_hop,
    input  logic [ADDR_W-1:0]   next_hop_in,
    input  logic [IFACE_W-1:0]  interface_in,
    input  logic [ADDR_W-1:0]   dest_addr,
    input  logic [TTL_W-1:0]    ttl_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [IFACE_W-1:0]  out_interface,
    output logic [ADDR_W-1:0]   hop_addr_out,
    output logic [TTL_W-1:0]    ttl_out
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
    localparam logic [8:0]       IFACE_LIMIT = 9'(NUM_INTERFACES);

    // Control state.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rd_pend_reg;
    logic             found_reg;
    logic             out_valid_reg;

    // Latched command and working payload.
    route_entry_t       add_entry_reg;
    logic [ADDR_W-1:0]  dest_reg;
    logic [TTL_W-1:0]   ttl_reg;
    route_entry_t       best_reg;
    status_t            res_status_reg, res_status_next;
    logic [IFACE_W-1:0] res_iface_reg, res_iface_next;
    logic [ADDR_W-1:0]  res_hop_reg, res_hop_next;
    logic [TTL_W-1:0]   res_ttl_reg, res_ttl_next;
    status_t            out_status_reg;
    logic [IFACE_W-1:0] out_iface_reg;
    logic [ADDR_W-1:0]  out_hop_reg;
    logic [TTL_W-1:0]   out_ttl_reg;

    // Sequencer outputs.
    logic in_accept;
    logic table_full;
    logic mem_we;
    logic mem_re;
    logic scan_last;
    logic out_load;
    logic take;

    route_entry_t rd_entry;
    route_entry_t new_entry;

    assign in_accept  = in_valid && !in_stall;
    assign table_full = (count_reg == FULL_COUNT);
    assign scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Entry built from the input beat, length saturated to 32.
    always_comb
    begin
        new_entry.prefix    = route_prefix_in;
        new_entry.length    = (route_length_in > MAX_LEN) ? MAX_LEN : route_length_in;
        new_entry.hop_valid = has_next_hop;
        new_entry.hop_addr  = next_hop_in;
        new_entry.iface     = interface_in;
    end

    ipv4lpm_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (add_entry_reg),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    ipv4lpm_match u_match (
        .dest       (dest_reg),
        .entry      (rd_entry),
        .best_found (found_reg),
        .best_len   (best_reg.length),
        .take       (take)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_RESOLVE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        mem_we   = (state_reg == S_ADD) && !table_full;
        mem_re   = (state_reg == S_SCAN);
        out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    // Result of the finished command.
    always_comb
    begin
        res_status_next = res_status_reg;
        res_iface_next  = res_iface_reg;
        res_hop_next    = res_hop_reg;
        res_ttl_next    = res_ttl_reg;
        case (state_reg)
            S_ADD:
            begin
                res_status_next = table_full ? ST_FULL : ST_ADDED;
                res_iface_next  = '0;
                res_hop_next    = '0;
                res_ttl_next    = '0;
            end
            S_RESOLVE:
            begin
                res_iface_next = '0;
                res_hop_next   = '0;
                res_ttl_next   = '0;
                if (!found_reg || ({5'd0, best_reg.iface} >= IFACE_LIMIT))
                begin
                    res_status_next = ST_NO_ROUTE;
                end
                else if (ttl_reg <= TTL_W'(1))
                begin
                    res_status_next = ST_TTL_EXPIRED;
                end
                else
                begin
                    res_status_next = ST_FORWARDED;
                    res_iface_next  = best_reg.iface;
                    res_hop_next    = best_reg.hop_valid ? best_reg.hop_addr : dest_reg;
                    res_ttl_next    = ttl_reg - TTL_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;
            if (mem_we)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (in_accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (mem_re)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (rd_pend_reg && take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            add_entry_reg <= new_entry;
            dest_reg      <= dest_addr;
            ttl_reg       <= ttl_in;
        end
        if (rd_pend_reg && take)
        begin
            best_reg <= rd_entry;
        end
        res_status_reg <= res_status_next;
        res_iface_reg  <= res_iface_next;
        res_hop_reg    <= res_hop_next;
        res_ttl_reg    <= res_ttl_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_iface_reg  <= res_iface_reg;
            out_hop_reg    <= res_hop_reg;
            out_ttl_reg    <= res_ttl_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign out_interface = out_iface_reg;
    assign hop_addr_out  = out_hop_reg;
    assign ttl_out       = out_ttl_reg;

endmodule

### rtl/core/ipv4lpm_checker.sv
// ----------------------------------------------------------------------------
// ipv4lpm_checker
// Port-level checks for the forwarding block, bound to its top level.
// ----------------------------------------------------------------------------
module ipv4lpm_checker
    import ipv4lpm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [2:0]          status,
    input logic [IFACE_W-1:0]  out_interface,
    input logic [ADDR_W-1:0]   hop_addr_out,
    input logic [TTL_W-1:0]    ttl_out
);

    // A stalled result beat holds its status and hop address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(hop_addr_out))
    else $error("stalled result beat changed");

    // One command at a time: an accepted beat blocks the input next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command was in work");

    // A new result only appears after a command was in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a command in work");

    // Only a forwarded datagram carries interface, hop and ttl.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_FORWARDED) |->
            (out_interface == '0) && (hop_addr_out == '0) && (ttl_out == '0))
    else $error("non-forwarded result carries payload");

    // A forwarded datagram always leaves with a live ttl.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FORWARDED) |-> (ttl_out != '0))
    else $error("forwarded datagram with zero ttl");

endmodule

bind ipv4_longest_prefix_router ipv4lpm_checker u_ipv4lpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_interface (out_interface),
    .hop_addr_out  (hop_addr_out),
    .ttl_out       (ttl_out)
);
